### src/rmq_pkg.sv
// shared types and constants for the rotation matrix to quaternion unit
// no dependencies
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int DATA_W    = 16;
    // width of a sum or difference of two matrix elements
    localparam int N_W       = 17;
    localparam int Q_MAX     = 32767;
    localparam int Q_MIN_MAG = 32768;

    typedef enum logic [1:0] {
        SEL_TRACE,
        SEL_X,
        SEL_Y,
        SEL_Z
    } rmq_sel_t;

    // classified item: branch, degenerate flag, numerators in w x y z order
    typedef struct packed {
        rmq_sel_t                  sel;
        logic                      degen;
        logic [3:0][N_W-1:0]       n;
    } rmq_cls_t;

endpackage

### src/rmq_if.sv
// request channels of the rotation matrix to quaternion unit
// depends on rmq_pkg
`timescale 1ns / 1ps

interface rmq_mat_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rmq_pkg::DATA_W-1:0]    m00;
    logic signed [rmq_pkg::DATA_W-1:0]    m01;
    logic signed [rmq_pkg::DATA_W-1:0]    m02;
    logic signed [rmq_pkg::DATA_W-1:0]    m10;
    logic signed [rmq_pkg::DATA_W-1:0]    m11;
    logic signed [rmq_pkg::DATA_W-1:0]    m12;
    logic signed [rmq_pkg::DATA_W-1:0]    m20;
    logic signed [rmq_pkg::DATA_W-1:0]    m21;
    logic signed [rmq_pkg::DATA_W-1:0]    m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
    modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface rmq_quat_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rmq_pkg::DATA_W-1:0]    q_w;
    logic signed [rmq_pkg::DATA_W-1:0]    q_x;
    logic signed [rmq_pkg::DATA_W-1:0]    q_y;
    logic signed [rmq_pkg::DATA_W-1:0]    q_z;
    logic                                 degenerate;

    modport source (output valid, q_w, q_x, q_y, q_z, degenerate, input ready);
    modport sink (input valid, q_w, q_x, q_y, q_z, degenerate, output ready);
endinterface

### src/rmq_front.sv
// front end: accepts a matrix request, picks the branch, forms the radicand
// and the off-diagonal numerators; depends on rmq_pkg and rmq_if
`timescale 1ns / 1ps

module rmq_front #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS
) (
    rmq_mat_if.sink                                   mat,
    input  logic                                      full,
    output logic                                      push,
    output rmq_pkg::rmq_cls_t                         cls,
    output logic [((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1:0] ru
);

    localparam int R_W  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
    localparam int RU_W = R_W - 1;
    localparam int NW   = rmq_pkg::N_W;

    logic signed [R_W-1:0] e00, e11, e22, one_s, trace, r;
    logic signed [NW-1:0]  d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;

    assign e00   = R_W'(mat.m00);
    assign e11   = R_W'(mat.m11);
    assign e22   = R_W'(mat.m22);
    assign one_s = {{(R_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    assign trace = e00 + e11 + e22;

    assign d21_12 = NW'(mat.m21) - NW'(mat.m12);
    assign d02_20 = NW'(mat.m02) - NW'(mat.m20);
    assign d10_01 = NW'(mat.m10) - NW'(mat.m01);
    assign s01_10 = NW'(mat.m01) + NW'(mat.m10);
    assign s02_20 = NW'(mat.m02) + NW'(mat.m20);
    assign s12_21 = NW'(mat.m12) + NW'(mat.m21);

    always_comb
    begin
        cls.n = '0;
        if (trace > 0)
        begin
            cls.sel  = rmq_pkg::SEL_TRACE;
            r        = one_s + trace;
            cls.n[1] = d21_12;
            cls.n[2] = d02_20;
            cls.n[3] = d10_01;
        end
        else if (mat.m00 > mat.m11 && mat.m00 > mat.m22)
        begin
            cls.sel  = rmq_pkg::SEL_X;
            r        = one_s + e00 - e11 - e22;
            cls.n[0] = d21_12;
            cls.n[2] = s01_10;
            cls.n[3] = s02_20;
        end
        else if (mat.m11 > mat.m22)
        begin
            cls.sel  = rmq_pkg::SEL_Y;
            r        = one_s + e11 - e00 - e22;
            cls.n[0] = d02_20;
            cls.n[1] = s01_10;
            cls.n[3] = s12_21;
        end
        else
        begin
            cls.sel  = rmq_pkg::SEL_Z;
            r        = one_s + e22 - e00 - e11;
            cls.n[0] = d10_01;
            cls.n[1] = s02_20;
            cls.n[2] = s12_21;
        end
        cls.degen = r[R_W-1] || (r == '0);
    end

    assign ru        = r[RU_W-1:0];
    assign mat.ready = !full;
    assign push      = mat.valid && !full;

endmodule

### src/rmq_queue.sv
// two-entry queue between front end and arithmetic back end
// depends on nothing
`timescale 1ns / 1ps

module rmq_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic         vld,
    output logic [W-1:0] dout
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   cnt_reg, cnt_next;

    assign full = (cnt_reg == 2'd2);
    assign vld  = (cnt_reg != 2'd0);
    assign dout = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### src/rmq_back.sv
// back end: pipelined square root, four pipelined dividers, saturation
// and output register; depends on rmq_pkg and rmq_if
`timescale 1ns / 1ps

module rmq_back #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      q_vld,
    input  rmq_pkg::rmq_cls_t                         q_cls,
    input  logic [((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1:0] q_ru,
    output logic                                      pop,
    rmq_quat_if.source                                quat
);

    localparam int R_W   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
    localparam int RU_W  = R_W - 1;
    localparam int S_W   = RU_W + FRAC_BITS;
    localparam int SQ_W  = S_W + (S_W % 2);
    localparam int RT_W  = SQ_W / 2;
    localparam int NW    = rmq_pkg::N_W;
    localparam int QW    = rmq_pkg::DATA_W;
    localparam int NUM_W = ((NW + FRAC_BITS > RT_W) ? NW + FRAC_BITS : RT_W) + 1;
    localparam int DV_W  = ((NUM_W > RT_W + QW + 1) ? NUM_W : RT_W + QW + 1) + 1;
    localparam int DV_N  = QW + 2;
    localparam int HW    = RT_W + QW + 1;

    typedef struct packed {
        rmq_pkg::rmq_cls_t cls;
        logic [SQ_W-1:0]   rad;
        logic [RT_W+1:0]   rem;
        logic [RT_W-1:0]   root;
    } sq_t;

    typedef struct packed {
        rmq_pkg::rmq_cls_t       cls;
        logic [RT_W-1:0]         root;
        logic [RT_W:0]           dvs;
        logic [3:0]              neg;
        logic [3:0]              ovf;
        logic [3:0][DV_W-1:0]    rem;
        logic [3:0][QW-1:0]      quo;
    } dv_t;

    logic                 en;
    logic                 out_vld_reg;
    logic [3:0][QW-1:0]   q_reg, q_next;
    logic                 degen_reg;

    sq_t                  sq_reg  [RT_W+1];
    sq_t                  sq_next [RT_W+1];
    logic [RT_W:0]        sq_vld_reg;
    dv_t                  dv_reg  [DV_N];
    dv_t                  dv_next [DV_N];
    logic [DV_N-1:0]      dv_vld_reg;
    logic [3:0]           sel_oh;

    // whole pipeline advances unless the output register holds an untaken result
    assign en  = !out_vld_reg || quat.ready;
    assign pop = q_vld && en;

    always_comb
    begin
        sq_next[0].cls  = q_cls;
        sq_next[0].rad  = SQ_W'({q_ru, {FRAC_BITS{1'b0}}});
        sq_next[0].rem  = '0;
        sq_next[0].root = '0;
    end

    // one result bit of the square root per stage
    for (genvar i = 0; i < RT_W; i++)
    begin : g_sqrt
        always_comb
        begin
            logic [RT_W+1:0] rt;
            logic [RT_W+1:0] tr;
            rt = {sq_reg[i].rem[RT_W-1:0], sq_reg[i].rad[SQ_W-1 -: 2]};
            tr = {sq_reg[i].root, 2'b01};
            sq_next[i+1]     = sq_reg[i];
            sq_next[i+1].rad = sq_reg[i].rad << 2;
            if (rt >= tr)
            begin
                sq_next[i+1].rem  = rt - tr;
                sq_next[i+1].root = {sq_reg[i].root[RT_W-2:0], 1'b1};
            end
            else
            begin
                sq_next[i+1].rem  = rt;
                sq_next[i+1].root = {sq_reg[i].root[RT_W-2:0], 1'b0};
            end
        end
    end

    // divider setup: magnitude, rounding offset and divisor 2*root
    always_comb
    begin
        logic [NW-1:0] mag;
        dv_next[0].cls  = sq_reg[RT_W].cls;
        dv_next[0].root = sq_reg[RT_W].root;
        dv_next[0].dvs  = {sq_reg[RT_W].root, 1'b0};
        dv_next[0].ovf  = '0;
        dv_next[0].quo  = '0;
        for (int l = 0; l < 4; l++)
        begin
            dv_next[0].neg[l] = sq_reg[RT_W].cls.n[l][NW-1];
            mag = dv_next[0].neg[l] ? (NW'(0) - sq_reg[RT_W].cls.n[l]) : sq_reg[RT_W].cls.n[l];
            dv_next[0].rem[l] = DV_W'({mag, {FRAC_BITS{1'b0}}}) + DV_W'(sq_reg[RT_W].root);
        end
    end

    // quotient too large for 16 bits saturates anyway
    always_comb
    begin
        dv_next[1] = dv_reg[0];
        for (int l = 0; l < 4; l++)
        begin
            dv_next[1].ovf[l] = dv_reg[0].rem[l] >= (DV_W'(dv_reg[0].dvs) << QW);
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        always_comb
        begin
            logic [DV_W-1:0] tr;
            tr = DV_W'(dv_reg[k+1].dvs) << (QW - 1 - k);
            dv_next[k+2] = dv_reg[k+1];
            for (int l = 0; l < 4; l++)
            begin
                if (dv_reg[k+1].rem[l] >= tr)
                begin
                    dv_next[k+2].rem[l]          = dv_reg[k+1].rem[l] - tr;
                    dv_next[k+2].quo[l][QW-1-k] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        case (dv_reg[DV_N-1].cls.sel)
            rmq_pkg::SEL_TRACE: sel_oh = 4'b0001;
            rmq_pkg::SEL_X:     sel_oh = 4'b0010;
            rmq_pkg::SEL_Y:     sel_oh = 4'b0100;
            rmq_pkg::SEL_Z:     sel_oh = 4'b1000;
            default:            sel_oh = 4'b0001;
        endcase
    end

    always_comb
    begin
        logic [RT_W:0]  half;
        logic [QW-1:0]  quo;
        half = ({1'b0, dv_reg[DV_N-1].root} + (RT_W+1)'(1)) >> 1;
        for (int l = 0; l < 4; l++)
        begin
            quo = dv_reg[DV_N-1].quo[l];
            if (dv_reg[DV_N-1].cls.degen)
            begin
                q_next[l] = '0;
            end
            else if (sel_oh[l])
            begin
                q_next[l] = (HW'(half) >= HW'(rmq_pkg::Q_MAX)) ? QW'(rmq_pkg::Q_MAX)
                                                                : QW'(half);
            end
            else if (dv_reg[DV_N-1].neg[l])
            begin
                q_next[l] = (dv_reg[DV_N-1].ovf[l] || quo >= QW'(rmq_pkg::Q_MIN_MAG))
                            ? QW'(rmq_pkg::Q_MIN_MAG) : (QW'(0) - quo);
            end
            else
            begin
                q_next[l] = (dv_reg[DV_N-1].ovf[l] || quo >= QW'(rmq_pkg::Q_MAX))
                            ? QW'(rmq_pkg::Q_MAX) : quo;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg  <= '0;
            dv_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_vld_reg  <= {sq_vld_reg[RT_W-1:0], pop};
            dv_vld_reg  <= {dv_vld_reg[DV_N-2:0], sq_vld_reg[RT_W]};
            out_vld_reg <= dv_vld_reg[DV_N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s <= RT_W; s++)
            begin
                sq_reg[s] <= sq_next[s];
            end
            for (int s = 0; s < DV_N; s++)
            begin
                dv_reg[s] <= dv_next[s];
            end
            if (dv_vld_reg[DV_N-1])
            begin
                q_reg     <= q_next;
                degen_reg <= dv_reg[DV_N-1].cls.degen;
            end
        end
    end

    assign quat.valid      = out_vld_reg;
    assign quat.q_w        = q_reg[0];
    assign quat.q_x        = q_reg[1];
    assign quat.q_y        = q_reg[2];
    assign quat.q_z        = q_reg[3];
    assign quat.degenerate = degen_reg;

endmodule

### src/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix to unit quaternion (Shepperd's method) in signed fixed point.
// Takes one matrix per clock and returns one quaternion per clock once the pipe is
// full, while the result side is not stalling. Most of the pipeline is the square
// root (one root bit per stage) and the divider (one quotient bit per stage over 16
// bits). A two-entry queue sits between the branch select front end and the arithmetic
// back end; back pressure on the result stalls the back end.
// depends on rmq_pkg, rmq_if, rmq_front, rmq_queue, rmq_back
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_unit #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    rmq_mat_if.sink     mat,
    rmq_quat_if.source  quat
);

    localparam int RU_W = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int QD_W = $bits(rmq_pkg::rmq_cls_t) + RU_W;

    logic                 push, full, q_vld, pop;
    rmq_pkg::rmq_cls_t    f_cls, b_cls;
    logic [RU_W-1:0]      f_ru, b_ru;
    logic [QD_W-1:0]      q_dout;

    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .mat  (mat),
        .full (full),
        .push (push),
        .cls  (f_cls),
        .ru   (f_ru)
    );

    rmq_queue #(.W(QD_W)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   ({f_cls, f_ru}),
        .full  (full),
        .pop   (pop),
        .vld   (q_vld),
        .dout  (q_dout)
    );

    assign b_cls = q_dout[QD_W-1:RU_W];
    assign b_ru  = q_dout[RU_W-1:0];

    rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .q_vld (q_vld),
        .q_cls (b_cls),
        .q_ru  (b_ru),
        .pop   (pop),
        .quat  (quat)
    );

endmodule

### src/rmq_checker.sv
// port level checks of the rotation matrix to quaternion unit, bound to the top
// depends on rotation_matrix_to_quaternion_unit
`timescale 1ns / 1ps

module rmq_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] q_w,
    input logic [15:0] q_x,
    input logic [15:0] q_y,
    input logic [15:0] q_z,
    input logic        degenerate
);

    logic [7:0] outst_reg, outst_next;

    assign outst_next = outst_reg + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= 8'd0;
        end
        else
        begin
            outst_reg <= outst_next;
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(q_w) && $stable(q_x)
                                    && $stable(q_y) && $stable(q_z) && $stable(degenerate))
        else $error("stalled result changed");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> q_w == 16'd0 && q_x == 16'd0 && q_y == 16'd0
                                    && q_z == 16'd0)
        else $error("degenerate result not zero");

    // the selected component is half a root of at least 128
    a_pos_comp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |-> (!q_w[15] && q_w != 16'd0) || (!q_x[15] && q_x != 16'd0)
                                     || (!q_y[15] && q_y != 16'd0) || (!q_z[15] && q_z != 16'd0))
        else $error("no positive component in result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> outst_reg != 8'd0)
        else $error("result without request");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_port_checker u_rmq_port_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (mat.valid),
    .in_ready   (mat.ready),
    .out_valid  (quat.valid),
    .out_ready  (quat.ready),
    .q_w        (quat.q_w),
    .q_x        (quat.q_x),
    .q_y        (quat.q_y),
    .q_z        (quat.q_z),
    .degenerate (quat.degenerate)
);

### sim/rmq_tb_if.sv
// testbench copies of nothing: interfaces come from the rtl; this file holds tb helpers
// depends on nothing
`timescale 1ns / 1ps

package rmq_tb_pkg;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               degenerate;
    } quat_t;

endpackage

### sim/rmq_checker.sv
// checker: predicts the quaternion of each accepted matrix request and compares results
// depends on rmq_pkg, rmq_if, rmq_tb_pkg
`timescale 1ns / 1ps

module rmq_checker (
    input  logic       clk,
    input  logic       rst_n,
    rmq_mat_if         mat,
    rmq_quat_if        quat,
    output int         fail_count,
    output int         pending
);
    import rmq_pkg::*;
    import rmq_tb_pkg::*;

    quat_t quat_expected[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] saturate(input logic neg, input longint mag);
        if (neg)
            return (mag >= Q_MIN_MAG) ? 16'sh8000 : 16'(-mag);
        return (mag >= Q_MAX) ? 16'sh7fff : 16'(mag);
    endfunction

    function automatic logic signed [15:0] scaled_quotient(input longint n, input longint root);
        logic   neg;
        longint mag;
        neg = n < 0;
        mag = neg ? -n : n;
        return saturate(neg, ((mag << FRAC_BITS) + root) / (root * 2));
    endfunction

    function automatic quat_t quaternion_of(input longint m[9]);
        longint   tr;
        longint   r;
        longint   n[4];
        longint   root;
        rmq_sel_t sel;
        logic signed [15:0] c[4];
        quat_t    q;
        tr = m[0] + m[4] + m[8];
        if (tr > 0)
        begin
            sel = SEL_TRACE;
            r = (64'sd1 << FRAC_BITS) + tr;
            n[1] = m[7] - m[5]; n[2] = m[2] - m[6]; n[3] = m[3] - m[1];
        end
        else if (m[0] > m[4] && m[0] > m[8])
        begin
            sel = SEL_X;
            r = (64'sd1 << FRAC_BITS) + m[0] - m[4] - m[8];
            n[0] = m[7] - m[5]; n[2] = m[1] + m[3]; n[3] = m[2] + m[6];
        end
        else if (m[4] > m[8])
        begin
            sel = SEL_Y;
            r = (64'sd1 << FRAC_BITS) + m[4] - m[0] - m[8];
            n[0] = m[2] - m[6]; n[1] = m[1] + m[3]; n[3] = m[5] + m[7];
        end
        else
        begin
            sel = SEL_Z;
            r = (64'sd1 << FRAC_BITS) + m[8] - m[0] - m[4];
            n[0] = m[3] - m[1]; n[1] = m[2] + m[6]; n[2] = m[5] + m[7];
        end
        if (r <= 0)
            return '{w: 0, x: 0, y: 0, z: 0, degenerate: 1'b1};
        root = int_sqrt(r << FRAC_BITS);
        for (int i = 0; i < 4; i++)
            c[i] = (i == int'(sel)) ? saturate(1'b0, (root + 1) >> 1)
                                    : scaled_quotient(n[i], root);
        q.w = c[0]; q.x = c[1]; q.y = c[2]; q.z = c[3];
        q.degenerate = 1'b0;
        return q;
    endfunction

    assign pending = quat_expected.size();

    always @(posedge clk or negedge rst_n)
    begin
        longint m[9];
        quat_t  exp_q;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (mat.valid && mat.ready)
            begin
                m = '{mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12,
                      mat.m20, mat.m21, mat.m22};
                quat_expected.push_back(quaternion_of(m));
            end
            if (quat.valid && quat.ready)
            begin
                if (quat_expected.size() == 0)
                begin
                    $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d deg=%0b",
                             $time, quat.q_w, quat.q_x, quat.q_y, quat.q_z, quat.degenerate);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_q = quat_expected.pop_front();
                    if (exp_q.w !== quat.q_w || exp_q.x !== quat.q_x || exp_q.y !== quat.q_y
                        || exp_q.z !== quat.q_z || exp_q.degenerate !== quat.degenerate)
                    begin
                        $display("%0t: expected w=%0d x=%0d y=%0d z=%0d deg=%0b, actual w=%0d x=%0d y=%0d z=%0d deg=%0b",
                                 $time, exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.degenerate,
                                 quat.q_w, quat.q_x, quat.q_y, quat.q_z, quat.degenerate);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### sim/rotation_matrix_to_quaternion_unit_tb.sv
// top of the testbench: clock, reset, matrix requests, result stalls and the verdict
// depends on rmq_pkg, rmq_if, rmq_tb_pkg, rmq_checker, rotation_matrix_to_quaternion_unit
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_unit_tb;
    import rmq_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    logic sink_hold = 1'b0;
    logic calm = 1'b0;

    rmq_mat_if  mat ();
    rmq_quat_if quat ();

    rotation_matrix_to_quaternion_unit dut (.clk(clk), .rst_n(rst_n), .mat(mat), .quat(quat));
    rmq_checker checker_i (.clk(clk), .rst_n(rst_n), .mat(mat), .quat(quat),
                           .fail_count(fail_count), .pending(pending));

    always #10 clk = ~clk;

    initial
    begin
        mat.valid = 1'b0;
        {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12, mat.m20, mat.m21, mat.m22} = '0;
        quat.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // result side stalls about a third of the time, none while calm unless held, and throughout one long hold
    always @(posedge clk)
    begin
        if (rst_n)
            quat.ready <= !sink_hold && (calm || $urandom_range(99) >= 32);
    end

    function automatic logic signed [15:0] pick_elem();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh4000;
            3: return -16'sh4000;
            4: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly near-rotation matrices from random unit-ish quaternions, some noise
    task automatic make_matrix(output logic signed [15:0] m[9]);
        longint a, b, c, d, s;
        if ($urandom_range(3) == 0)
        begin
            for (int i = 0; i < 9; i++)
                m[i] = pick_elem();
            return;
        end
        a = longint'($urandom_range(32767)) - 16384;
        b = longint'($urandom_range(32767)) - 16384;
        c = longint'($urandom_range(32767)) - 16384;
        d = longint'($urandom_range(32767)) - 16384;
        s = a*a + b*b + c*c + d*d;
        if (s == 0)
            s = 1;
        m[0] = 16'(16384 - (2*(c*c + d*d) << 14) / s);
        m[4] = 16'(16384 - (2*(b*b + d*d) << 14) / s);
        m[8] = 16'(16384 - (2*(b*b + c*c) << 14) / s);
        m[1] = 16'((2*(b*c - a*d) << 14) / s);
        m[3] = 16'((2*(b*c + a*d) << 14) / s);
        m[2] = 16'((2*(b*d + a*c) << 14) / s);
        m[6] = 16'((2*(b*d - a*c) << 14) / s);
        m[5] = 16'((2*(c*d - a*b) << 14) / s);
        m[7] = 16'((2*(c*d + a*b) << 14) / s);
    endtask

    task automatic send(input logic signed [15:0] m[9], input bit may_idle);
        while (may_idle && !calm && $urandom_range(99) < 32)
        begin
            mat.valid <= 1'b0;
            @(posedge clk);
        end
        mat.valid <= 1'b1;
        {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12, mat.m20, mat.m21, mat.m22}
            <= {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
        @(posedge clk);
        while (!mat.ready)
            @(posedge clk);
    endtask

    // long hold on the result side so the pipe fills and stalls requests
    initial
    begin
        wait (rst_n);
        repeat (300) @(posedge clk);
        sink_hold <= 1'b1;
        repeat (200) @(posedge clk);
        sink_hold <= 1'b0;
    end

    initial
    begin
        logic signed [15:0] m[9];
        @(posedge rst_n);
        @(posedge clk);
        // identity, each diagonal branch, degenerate and extremes
        m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};     send(m, 1);
        m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};   send(m, 1);
        m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};   send(m, 1);
        m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};   send(m, 1);
        m = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};  send(m, 1);
        m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384};  send(m, 1);
        m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}; send(m, 1);
        m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
        send(m, 1);
        m = '{0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0}; send(m, 1);
        m = '{0, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0}; send(m, 1);
        m = '{32767, -32768, 32767, -32768, -32768, 32767, 32767, 32767, -32768}; send(m, 1);
        m = '{-32768, 32767, -32768, 32767, 32767, -32768, -32768, -32768, 32767}; send(m, 1);
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                 send(m, 1);
        m = '{1, 0, 0, 0, 0, 0, 0, 0, 0};                 send(m, 1);
        for (int i = 0; i < 900; i++)
        begin
            if (i == 450)
            begin
                // drain fully before going on
                mat.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            calm <= (i >= 600 && i < 700);
            make_matrix(m);
            send(m, 1);
        end
        mat.valid <= 1'b0;
        calm <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
